### rtl/bsrm_pkg.sv
// bsrm_pkg: types, codes and sequencer states for the backing-store region map
// used by bsrm_unit, bsrm_table and backing_store_region_map
// no dependencies
package bsrm_pkg;

  // input beat
  typedef struct packed {
    logic [1:0]  command;
    logic [6:0]  pid;
    logic [19:0] vpage;
    logic [3:0]  store_id;
    logic [7:0]  page_count;
  } in_item_t;

  // result beat
  typedef struct packed {
    logic [2:0] status;
    logic [2:0] found_store;
    logic [7:0] page_offset;
  } out_item_t;

  // command codes
  localparam logic [1:0] CMD_MAP    = 2'd0;
  localparam logic [1:0] CMD_LOOKUP = 2'd1;
  localparam logic [1:0] CMD_REMOVE = 2'd2;

  // status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_PID   = 3'd1;
  localparam logic [2:0] ST_LOW_PAGE  = 3'd2;
  localparam logic [2:0] ST_BAD_STORE = 3'd3;
  localparam logic [2:0] ST_BAD_COUNT = 3'd4;
  localparam logic [2:0] ST_NOT_FOUND = 3'd5;

  // configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_USER_PAGE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PROCESS_COUNT   = 1'd1;

  // configuration reset values
  localparam logic [19:0] FIRST_USER_PAGE_RST = 20'd4096;
  localparam logic [7:0]  PROCESS_COUNT_RST   = 8'd100;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK_PID,
    S_CHECK_PAGE,
    S_CHECK_STORE,
    S_CHECK_COUNT,
    S_SCAN,
    S_NOP
  } state_t;

  // shared compare unit request and response
  typedef struct packed {
    logic [19:0] a;
    logic [19:0] b;
    logic [7:0]  limit;
  } unit_req_t;

  typedef struct packed {
    logic        lt;
    logic [19:0] diff;
    logic        in_range;
  } unit_rsp_t;

  // one table entry as read out
  typedef struct packed {
    logic        valid;
    logic [6:0]  owner;
    logic [19:0] base;
    logic [7:0]  pages;
  } entry_t;

  // table write / clear request
  typedef struct packed {
    logic        wr_en;
    logic        clr_en;
    logic [6:0]  owner;
    logic [19:0] base;
    logic [7:0]  pages;
  } tbl_wr_t;

endpackage

### rtl/bsrm_unit.sv
// bsrm_unit: shared subtract / compare unit of the region map sequencer
// gives a < b, a - b and whether a - b falls below an 8-bit limit
// depends on bsrm_pkg
module bsrm_unit
  import bsrm_pkg::*;
(
  input  unit_req_t req,
  output unit_rsp_t rsp
);

  logic [20:0] diff_w;

  assign diff_w = {1'b0, req.a} - {1'b0, req.b};

  always_comb begin
    rsp.lt       = diff_w[20];
    rsp.diff     = diff_w[19:0];
    rsp.in_range = !diff_w[20] && (diff_w[19:8] == 12'd0) && (diff_w[7:0] < req.limit);
  end

endmodule

### rtl/bsrm_table.sv
// bsrm_table: region entries, one write or clear port and one read port
// valid marks reset to zero, entry payload is only read behind a valid mark
// depends on bsrm_pkg
module bsrm_table
  import bsrm_pkg::*;
#(
  parameter int STORES = 8,
  parameter int IDX_W  = 3
) (
  input  logic             clk,
  input  logic             rst_n,
  input  tbl_wr_t          wr,
  input  logic [IDX_W-1:0] wr_idx,
  input  logic [IDX_W-1:0] rd_idx,
  output entry_t           rd
);

  logic [STORES-1:0] valid_r;
  logic [6:0]        owner_r [STORES];
  logic [19:0]       base_r  [STORES];
  logic [7:0]        pages_r [STORES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr.wr_en) begin
      valid_r[wr_idx] <= 1'b1;
    end else if (wr.clr_en) begin
      valid_r[wr_idx] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.wr_en) begin
      owner_r[wr_idx] <= wr.owner;
      base_r[wr_idx]  <= wr.base;
      pages_r[wr_idx] <= wr.pages;
    end
  end

  always_comb begin
    rd.valid = valid_r[rd_idx];
    rd.owner = owner_r[rd_idx];
    rd.base  = base_r[rd_idx];
    rd.pages = pages_r[rd_idx];
  end

endmodule

### rtl/backing_store_region_map.sv
// backing_store_region_map: a map runs the pid, page, store and count checks in turn and a failed
// check ends it early; a lookup runs the pid and page checks, then scans entries in index order
// until a hit or the last entry (a miss); a remove scans for the first entry owned by the pid; an
// undefined command gives an ok result; one item in flight, a new beat is taken only from idle
// sync reset clears entry valid marks, sequencer and output; config regs go to 4096 and 100
// depends on bsrm_pkg, bsrm_unit, bsrm_table
module backing_store_region_map
  import bsrm_pkg::*;
#(
  parameter int STORES    = 8,
  parameter int MAX_PAGES = 200
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // command input
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_data,
  // result output
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_data,
  // register writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [19:0]          cfg_data
);

  localparam int IDX_W = (STORES > 1) ? $clog2(STORES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(STORES - 1);

  // config registers
  logic [19:0] fup_r;
  logic [7:0]  pcount_r;

  // sequencer state and the held command beat
  state_t           state_r, state_nxt;
  in_item_t         item_r, item_nxt;
  logic [IDX_W-1:0] scan_r, scan_nxt;

  // result register
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r, out_data_nxt;
  logic      out_load;
  logic      out_free;

  // shared unit and table
  unit_req_t        ureq;
  unit_rsp_t        ursp;
  tbl_wr_t          tbl_wr;
  logic [IDX_W-1:0] tbl_idx;
  entry_t           entry;
  logic             owner_hit;

  bsrm_unit u_unit (
    .req (ureq),
    .rsp (ursp)
  );

  bsrm_table #(
    .STORES (STORES),
    .IDX_W  (IDX_W)
  ) u_table (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr     (tbl_wr),
    .wr_idx (tbl_idx),
    .rd_idx (scan_r),
    .rd     (entry)
  );

  // register port is always able to take a write; the user must write only while idle, the block does not enforce it
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fup_r    <= FIRST_USER_PAGE_RST;
      pcount_r <= PROCESS_COUNT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_FIRST_USER_PAGE: fup_r    <= cfg_data;
        CFG_PROCESS_COUNT:   pcount_r <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // one item at a time: take a beat only from idle
  assign in_stall = (state_r != S_IDLE);

  // the result slot is free when empty or being drained this cycle
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // entry under the scan pointer belongs to the asking pid
  assign owner_hit = entry.valid && (entry.owner == item_r.pid);

  // the table index is the map target while writing, else the scan pointer
  assign tbl_idx = (state_r == S_CHECK_COUNT) ? IDX_W'(item_r.store_id) : scan_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      scan_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      scan_r      <= scan_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    if (out_load) begin
      out_data_r <= out_data_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    item_nxt     = item_r;
    scan_nxt     = scan_r;
    out_load     = 1'b0;
    out_data_nxt = '0;
    ureq         = '0;
    tbl_wr       = '0;
    tbl_wr.owner = item_r.pid;
    tbl_wr.base  = item_r.vpage;
    tbl_wr.pages = item_r.page_count;

    case (state_r)
      S_IDLE: begin
        if (in_valid && !in_stall) begin
          item_nxt = in_data;
          scan_nxt = '0;
          case (in_data.command)
            CMD_MAP, CMD_LOOKUP: state_nxt = S_CHECK_PID;
            CMD_REMOVE:          state_nxt = S_SCAN;
            default:             state_nxt = S_NOP;
          endcase
        end
      end

      // pid must be nonzero and below process_count
      S_CHECK_PID: begin
        ureq.a = 20'(item_r.pid);
        ureq.b = 20'(pcount_r);
        if (item_r.pid == 7'd0 || !ursp.lt) begin
          out_data_nxt.status = ST_BAD_PID;
          if (out_free) begin
            out_load  = 1'b1;
            state_nxt = S_IDLE;
          end
        end else begin
          state_nxt = S_CHECK_PAGE;
        end
      end

      // page must not be below first_user_page
      S_CHECK_PAGE: begin
        ureq.a = item_r.vpage;
        ureq.b = fup_r;
        if (ursp.lt) begin
          out_data_nxt.status = ST_LOW_PAGE;
          if (out_free) begin
            out_load  = 1'b1;
            state_nxt = S_IDLE;
          end
        end else if (item_r.command == CMD_MAP) begin
          state_nxt = S_CHECK_STORE;
        end else begin
          state_nxt = S_SCAN;
        end
      end

      // store index must be below STORES
      S_CHECK_STORE: begin
        ureq.a = 20'(item_r.store_id);
        ureq.b = 20'(STORES);
        if (!ursp.lt) begin
          out_data_nxt.status = ST_BAD_STORE;
          if (out_free) begin
            out_load  = 1'b1;
            state_nxt = S_IDLE;
          end
        end else begin
          state_nxt = S_CHECK_COUNT;
        end
      end

      // count must not exceed MAX_PAGES, then write the entry
      S_CHECK_COUNT: begin
        ureq.a = 20'(MAX_PAGES);
        ureq.b = 20'(item_r.page_count);
        out_data_nxt.status = ursp.lt ? ST_BAD_COUNT : ST_OK;
        if (out_free) begin
          out_load     = 1'b1;
          tbl_wr.wr_en = !ursp.lt;
          state_nxt    = S_IDLE;
        end
      end

      // one entry per cycle in index order
      S_SCAN: begin
        ureq.a     = item_r.vpage;
        ureq.b     = entry.base;
        ureq.limit = entry.pages;
        if (item_r.command == CMD_REMOVE && owner_hit) begin
          out_data_nxt.status = ST_OK;
          if (out_free) begin
            out_load      = 1'b1;
            tbl_wr.clr_en = 1'b1;
            state_nxt     = S_IDLE;
          end
        end else if (item_r.command != CMD_REMOVE && owner_hit && ursp.in_range) begin
          out_data_nxt.status      = ST_OK;
          out_data_nxt.found_store = 3'(scan_r);
          out_data_nxt.page_offset = ursp.diff[7:0];
          if (out_free) begin
            out_load  = 1'b1;
            state_nxt = S_IDLE;
          end
        end else if (scan_r == LAST_IDX) begin
          out_data_nxt.status = ST_NOT_FOUND;
          if (out_free) begin
            out_load  = 1'b1;
            state_nxt = S_IDLE;
          end
        end else begin
          scan_nxt = scan_r + IDX_W'(1);
        end
      end

      // undefined command: no change, ok status
      S_NOP: begin
        out_data_nxt.status = ST_OK;
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // result register: load, hold while stalled, drop once taken
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // scan pointer never leaves the table
  a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SCAN |-> scan_r <= LAST_IDX)
    else $error("scan pointer past last entry");

  // an entry is written only by a map that passed the store check
  a_write_guard: assert property (@(posedge clk) disable iff (!rst_n)
    tbl_wr.wr_en |-> (state_r == S_CHECK_COUNT) && (item_r.command == CMD_MAP)
                     && (20'(item_r.store_id) < 20'(STORES)))
    else $error("table write outside a checked map");

  // a remove only clears an entry that is valid and owned by the pid
  a_clear_guard: assert property (@(posedge clk) disable iff (!rst_n)
    tbl_wr.clr_en |-> owner_hit && (item_r.command == CMD_REMOVE))
    else $error("clear of an entry not owned by the pid");

  // loading a result ends the item
  a_load_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (state_r == S_IDLE) && out_valid_r)
    else $error("sequencer busy after result load");

endmodule

### dv/backing_store_region_map_tb.sv
`timescale 1ns / 100ps
// backing_store_region_map_tb: self-checking bench for the backing-store region map
// drives directed and random command beats, predicts each result beat and checks it in order
// depends on bsrm_pkg and backing_store_region_map
module backing_store_region_map_tb;
  import bsrm_pkg::*;

  localparam int STORES       = 8;
  localparam int MAX_PAGES    = 200;
  localparam logic [1:0] CMD_UNDEF = 2'd3;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int LONG_HOLD    = 400;
  // longest item is a lookup that scans up to the last entry
  localparam int DRAIN_CYCLES = 32;
  // small pid pool so several regions share an owner
  localparam int PID_POOL     = 6;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  in_item_t             in_data   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_item_t            out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [19:0]          cfg_data  = '0;

  backing_store_region_map #(
    .STORES   (STORES),
    .MAX_PAGES(MAX_PAGES)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #5 clk = ~clk;

  // command beats waiting to be offered, result beats still owed by the block
  in_item_t  cmd_backlog[$];
  out_item_t results_due[$];

  int   mismatch_count = 0;
  int   result_count   = 0;
  int   cycle_count    = 0;
  int   send_gap       = 0;
  int   rx_gap         = 0;
  logic idle_on        = 1'b0;
  logic hold_arm       = 1'b0;
  logic rx_hold        = 1'b0;

  // predicted region table and register copies
  logic        tbl_valid [STORES];
  logic [6:0]  tbl_owner [STORES];
  logic [19:0] tbl_base  [STORES];
  logic [7:0]  tbl_pages [STORES];
  logic [19:0] first_page = FIRST_USER_PAGE_RST;
  logic [7:0]  proc_count = PROCESS_COUNT_RST;

  // regions the stimulus has asked for, used to aim lookups at real ranges
  logic        plan_used [STORES];
  logic [6:0]  plan_pid  [STORES];
  logic [19:0] plan_base [STORES];
  logic [7:0]  plan_cnt  [STORES];

  function automatic logic pid_valid(input logic [6:0] pid);
    return pid != 7'd0 && {1'b0, pid} < proc_count;
  endfunction

  // applies one command beat to the predicted table and returns its result beat
  function automatic out_item_t translate_cmd(input in_item_t c);
    out_item_t   r;
    logic        hit;
    logic [20:0] end_excl;
    logic [19:0] page_diff;
    r   = '0;
    hit = 1'b0;
    case (c.command)
      CMD_MAP: begin
        // checks in order pid, page, store, count; first failure wins
        if (!pid_valid(c.pid)) r.status = ST_BAD_PID;
        else if (c.vpage < first_page) r.status = ST_LOW_PAGE;
        else if (c.store_id >= STORES) r.status = ST_BAD_STORE;
        else if (c.page_count > MAX_PAGES) r.status = ST_BAD_COUNT;
        else begin
          // overwrites even a live entry
          tbl_valid[c.store_id] = 1'b1;
          tbl_owner[c.store_id] = c.pid;
          tbl_base[c.store_id]  = c.vpage;
          tbl_pages[c.store_id] = c.page_count;
        end
      end
      CMD_LOOKUP: begin
        if (!pid_valid(c.pid)) r.status = ST_BAD_PID;
        else if (c.vpage < first_page) r.status = ST_LOW_PAGE;
        else begin
          r.status = ST_NOT_FOUND;
          for (int i = 0; i < STORES; i++) begin
            // exclusive end, computed one bit wider so a top-of-space region does not wrap
            end_excl = {1'b0, tbl_base[i]} + {13'd0, tbl_pages[i]};
            if (!hit && tbl_valid[i] && tbl_owner[i] == c.pid &&
                c.vpage >= tbl_base[i] && {1'b0, c.vpage} < end_excl) begin
              hit           = 1'b1;
              page_diff     = c.vpage - tbl_base[i];
              r.status      = ST_OK;
              r.found_store = 3'(i);
              r.page_offset = page_diff[7:0];
            end
          end
        end
      end
      CMD_REMOVE: begin
        // no pid check; clears the lowest-index live entry of the owner
        r.status = ST_NOT_FOUND;
        for (int i = 0; i < STORES; i++) begin
          if (!hit && tbl_valid[i] && tbl_owner[i] == c.pid) begin
            hit          = 1'b1;
            tbl_valid[i] = 1'b0;
            r.status     = ST_OK;
          end
        end
      end
      default: begin
        // undefined command: no change, status ok
      end
    endcase
    return r;
  endfunction

  function automatic in_item_t make_cmd(input logic [1:0] command, input logic [6:0] pid,
                                        input logic [19:0] vpage, input logic [3:0] store_id,
                                        input logic [7:0] page_count);
    in_item_t c;
    c.command    = command;
    c.pid        = pid;
    c.vpage      = vpage;
    c.store_id   = store_id;
    c.page_count = page_count;
    return c;
  endfunction

  // pid below the current process count when that is above 1, else pid 1; mostly from a small pool
  function automatic logic [6:0] pick_pid();
    int unsigned pid_hi;
    pid_hi = (proc_count > 8'd1) ? int'(proc_count) - 1 : 1;
    if ($urandom_range(0, 3) != 0 && pid_hi > PID_POOL) pid_hi = PID_POOL;
    return 7'($urandom_range(pid_hi, 1));
  endfunction

  // page at or above the first user page, half the time close to it
  function automatic logic [19:0] pick_page();
    int unsigned lo, hi;
    lo = first_page;
    hi = 20'hFFFFF;
    if ($urandom_range(0, 1) == 0 && lo + 700 < hi) hi = lo + 700;
    return 20'($urandom_range(hi, lo));
  endfunction

  // mostly well-formed maps and aimed lookups, some removes, the rest raw noise
  function automatic in_item_t random_cmd();
    in_item_t    c;
    int unsigned roll, sid;
    roll         = $urandom_range(0, 99);
    c.command    = CMD_MAP;
    c.pid        = pick_pid();
    c.vpage      = pick_page();
    c.store_id   = 4'($urandom_range(STORES - 1, 0));
    c.page_count = ($urandom_range(0, 9) == 0) ? 8'd0 : 8'($urandom_range(MAX_PAGES, 1));
    if (roll < 35) begin
      plan_used[c.store_id] = 1'b1;
      plan_pid[c.store_id]  = c.pid;
      plan_base[c.store_id] = c.vpage;
      plan_cnt[c.store_id]  = c.page_count;
    end else if (roll < 72) begin
      c.command = CMD_LOOKUP;
      sid       = $urandom_range(STORES - 1, 0);
      if (plan_used[sid]) begin
        // inside the region or just past either end
        c.pid   = ($urandom_range(0, 7) == 0) ? pick_pid() : plan_pid[sid];
        c.vpage = plan_base[sid] + 20'($urandom_range(int'(plan_cnt[sid]) + 1, 0));
        if ($urandom_range(0, 9) == 0) c.vpage = plan_base[sid] - 20'd1;
      end
    end else if (roll < 82) begin
      c.command = CMD_REMOVE;
    end else begin
      c.command    = 2'($urandom_range(3, 0));
      c.pid        = 7'($urandom);
      c.vpage      = 20'($urandom);
      c.store_id   = 4'($urandom);
      c.page_count = 8'($urandom);
    end
    return c;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (results_due.size() == 0) begin
      report_mismatch($sformatf("result beat %0d with nothing pending, status %0d",
                                result_count, got.status));
    end else begin
      want = results_due.pop_front();
      if (got.status !== want.status)
        report_mismatch($sformatf("beat %0d status %0d, want %0d",
                                  result_count, got.status, want.status));
      if (got.found_store !== want.found_store)
        report_mismatch($sformatf("beat %0d found_store %0d, want %0d",
                                  result_count, got.found_store, want.found_store));
      if (got.page_offset !== want.page_offset)
        report_mismatch($sformatf("beat %0d page_offset %0d, want %0d",
                                  result_count, got.page_offset, want.page_offset));
    end
    result_count++;
  endtask

  // register write; only called with the block idle
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [19:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_FIRST_USER_PAGE) first_page = value;
    else proc_count = value[7:0];
  endtask

  // sender side pauses until every owed result beat has come back;
  // sampled between edges so the driver and monitor updates have settled
  task automatic wait_drained();
    while (cmd_backlog.size() != 0 || in_valid || results_due.size() != 0) @(negedge clk);
  endtask

  task automatic run_phase(input logic [19:0] fup, input logic [19:0] pc_word,
                           input int beats, input logic idle, input logic hold);
    write_reg(CFG_FIRST_USER_PAGE, fup);
    write_reg(CFG_PROCESS_COUNT, pc_word);
    idle_on = idle;
    for (int n = 0; n < beats; n++) cmd_backlog.push_back(random_cmd());
    if (hold) hold_arm = 1'b1;
    wait_drained();
  endtask

  // driver: offers the next beat once the current one is taken, with random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        results_due.push_back(translate_cmd(in_data));
      end
      // a stalled beat stays on the bus unchanged
      if (!in_valid || !in_stall) begin
        if (send_gap != 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (cmd_backlog.size() != 0) begin
          in_data  <= cmd_backlog.pop_front();
          in_valid <= 1'b1;
          if (idle_on && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 15);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks each taken result beat and stalls in random bursts
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) check_result(out_data);
      if (rx_hold) begin
        out_stall <= 1'b1;
      end else if (rx_gap != 0) begin
        rx_gap--;
        out_stall <= 1'b1;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        // burst of random length, this cycle included
        rx_gap = $urandom_range(0, 14);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // long receiver hold-off so the block backs up and stalls its input
  initial begin
    wait (hold_arm);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (LONG_HOLD) @(posedge clk);
    rx_hold <= 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d result beats still owed",
               cycle_count, results_due.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < STORES; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_owner[i] = '0;
      tbl_base[i]  = '0;
      tbl_pages[i] = '0;
      plan_used[i] = 1'b0;
      plan_pid[i]  = '0;
      plan_base[i] = '0;
      plan_cnt[i]  = '0;
    end
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed beats at the reset register values (first page 4096, 100 processes)
    idle_on = 1'b1;
    // empty table
    cmd_backlog.push_back(make_cmd(CMD_LOOKUP, 7'd5, 20'd5000, 4'd0, 8'd0));
    cmd_backlog.push_back(make_cmd(CMD_REMOVE, 7'd5, 20'd0, 4'd0, 8'd0));
    // pid limits: null process, equal to process count, top of field
    cmd_backlog.push_back(make_cmd(CMD_MAP, 7'd0, 20'd4096, 4'd0, 8'd10));
    cmd_backlog.push_back(make_cmd(CMD_MAP, 7'd100, 20'd4096, 4'd0, 8'd10));
    cmd_backlog.push_back(make_cmd(CMD_MAP, 7'd127, 20'd4096, 4'd0, 8'd10));
    // page just below the first user page
    cmd_backlog.push_back(make_cmd(CMD_MAP, 7'd1, 20'd4095, 4'd0, 8'd10));
    // store out of range, and store checked before count
    cmd_backlog.push_back(make_cmd(CMD_MAP, 7'd1, 20'd4096, 4'd8, 8'd10));
    cmd_backlog.push_back(make_cmd(CMD_MAP, 7'd1, 20'd4096, 4'd15, 8'd255));
    // count one over the limit
    cmd_backlog.push_back(make_cmd(CMD_MAP, 7'd1, 20'd4096, 4'd0, 8'd201));
    // every check failing: pid wins
    cmd_backlog.push_back(make_cmd(CMD_MAP, 7'd0, 20'd0, 4'd15, 8'd255));
    // largest legal region, then an empty region ahead of it in the scan
    cmd_backlog.push_back(make_cmd(CMD_MAP, 7'd1, 20'd4096, 4'd3, 8'd200));
    cmd_backlog.push_back(make_cmd(CMD_MAP, 7'd1, 20'd4100, 4'd1, 8'd0));
    cmd_backlog.push_back(make_cmd(CMD_LOOKUP, 7'd1, 20'd4100, 4'd0, 8'd0));
    // last page in range and first page past the exclusive end
    cmd_backlog.push_back(make_cmd(CMD_LOOKUP, 7'd1, 20'd4295, 4'd0, 8'd0));
    cmd_backlog.push_back(make_cmd(CMD_LOOKUP, 7'd1, 20'd4296, 4'd0, 8'd0));
    // region at the top of the page space, highest legal pid
    cmd_backlog.push_back(make_cmd(CMD_MAP, 7'd99, 20'hFFFFF, 4'd7, 8'd200));
    cmd_backlog.push_back(make_cmd(CMD_LOOKUP, 7'd99, 20'hFFFFF, 4'd0, 8'd0));
    // lookup rejections
    cmd_backlog.push_back(make_cmd(CMD_LOOKUP, 7'd0, 20'd4096, 4'd0, 8'd0));
    cmd_backlog.push_back(make_cmd(CMD_LOOKUP, 7'd2, 20'd4000, 4'd0, 8'd0));
    // overlapping region at a lower index wins the scan
    cmd_backlog.push_back(make_cmd(CMD_MAP, 7'd1, 20'd4200, 4'd0, 8'd50));
    cmd_backlog.push_back(make_cmd(CMD_LOOKUP, 7'd1, 20'd4210, 4'd0, 8'd0));
    // remap a live store to another owner
    cmd_backlog.push_back(make_cmd(CMD_MAP, 7'd2, 20'd4096, 4'd0, 8'd10));
    // remove takes the lowest owned index (the empty region)
    cmd_backlog.push_back(make_cmd(CMD_REMOVE, 7'd1, 20'd0, 4'd0, 8'd0));
    cmd_backlog.push_back(make_cmd(CMD_UNDEF, 7'h7F, 20'hFFFFF, 4'hF, 8'hFF));
    cmd_backlog.push_back(make_cmd(CMD_REMOVE, 7'd99, 20'd0, 4'd0, 8'd0));
    wait_drained();

    // random phases, register extremes among them; first one holds off the receiver
    run_phase(20'd0, 20'd128, 420, 1'b1, 1'b1);
    run_phase(20'hFFFFF, 20'd128, 90, 1'b1, 1'b0);
    run_phase(20'($urandom_range(600000, 1000)), 20'd1, 70, 1'b1, 1'b0);
    // junk above bit 7 of the process count word
    run_phase(20'($urandom_range(900000, 4096)),
              {12'($urandom), 8'($urandom_range(127, 2))}, 400, 1'b1, 1'b0);
    run_phase(FIRST_USER_PAGE_RST, {12'd0, PROCESS_COUNT_RST}, 400, 1'b1, 1'b0);
    // closing stretch with no idling on either side
    run_phase(20'($urandom_range(200000, 0)), 20'd128, 170, 1'b0, 1'b0);

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### files.f
rtl/bsrm_pkg.sv
rtl/bsrm_unit.sv
rtl/bsrm_table.sv
rtl/backing_store_region_map.sv
dv/backing_store_region_map_tb.sv
